/* rtl/bfra_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfra_pkg: shared types and codes for the best-fit range allocator
// Status codes, free-list update codes and fixed field widths.
// ----------------------------------------------------------------------------
package bfra_pkg;

  // Fixed field widths of the request and result beats
  localparam int COUNT_W = 13;
  localparam int START_W = 12;
  localparam int BASE_W  = 12;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK   = 2'd0;
  localparam status_t ST_OOS  = 2'd1;
  localparam status_t ST_FULL = 2'd2;

  localparam logic KIND_ALLOC = 1'b0;

  // Free-list update operations
  typedef logic [2:0] list_op_t;
  localparam list_op_t OP_NONE      = 3'd0;
  localparam list_op_t OP_SET_BEGIN = 3'd1;
  localparam list_op_t OP_SET_END   = 3'd2;
  localparam list_op_t OP_DROP      = 3'd3;
  localparam list_op_t OP_INSERT    = 3'd4;

endpackage

/* rtl/bfra_list.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfra_list: sorted free-range store
// Begin/end register file with one read port and one update per cycle:
// set a begin, set an end, drop an entry (close the gap) or insert one.
// ----------------------------------------------------------------------------
module bfra_list #(
  parameter int DEPTH = 16,
  parameter int VW    = 13,
  localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic               clk,
  input  logic [IW-1:0]      rd_idx,
  output logic [VW-1:0]      rd_begin,
  output logic [VW-1:0]      rd_end,
  input  bfra_pkg::list_op_t op,
  input  logic [IW-1:0]      op_idx,
  input  logic [VW-1:0]      op_begin,
  input  logic [VW-1:0]      op_end
);

  logic [VW-1:0] range_begin_r [DEPTH];
  logic [VW-1:0] range_end_r   [DEPTH];

  // Neighbor taps: entry above (for drop) and below (for insert)
  wire  [VW-1:0] up_begin_w [DEPTH];
  wire  [VW-1:0] up_end_w   [DEPTH];
  wire  [VW-1:0] dn_begin_w [DEPTH];
  wire  [VW-1:0] dn_end_w   [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_tap
    if (k < DEPTH - 1) begin : g_up
      assign up_begin_w[k] = range_begin_r[k+1];
      assign up_end_w[k]   = range_end_r[k+1];
    end else begin : g_up_last
      assign up_begin_w[k] = '0;
      assign up_end_w[k]   = '0;
    end
    if (k > 0) begin : g_dn
      assign dn_begin_w[k] = range_begin_r[k-1];
      assign dn_end_w[k]   = range_end_r[k-1];
    end else begin : g_dn_first
      assign dn_begin_w[k] = '0;
      assign dn_end_w[k]   = '0;
    end
  end

  assign rd_begin = range_begin_r[rd_idx];
  assign rd_end   = range_end_r[rd_idx];

  always_ff @(posedge clk) begin
    for (int k = 0; k < DEPTH; k++) begin
      unique case (op)
        bfra_pkg::OP_SET_BEGIN: begin
          if (op_idx == IW'(k)) range_begin_r[k] <= op_begin;
        end
        bfra_pkg::OP_SET_END: begin
          if (op_idx == IW'(k)) range_end_r[k] <= op_end;
        end
        bfra_pkg::OP_DROP: begin
          if (IW'(k) >= op_idx) begin
            range_begin_r[k] <= up_begin_w[k];
            range_end_r[k]   <= up_end_w[k];
          end
        end
        bfra_pkg::OP_INSERT: begin
          if (IW'(k) == op_idx) begin
            range_begin_r[k] <= op_begin;
            range_end_r[k]   <= op_end;
          end else if (IW'(k) > op_idx) begin
            range_begin_r[k] <= dn_begin_w[k];
            range_end_r[k]   <= dn_end_w[k];
          end
        end
        default: ;
      endcase
    end
  end

endmodule

/* rtl/best_fit_range_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// best_fit_range_allocator: contiguous slot-range allocator with coalescing
// Allocate takes an exact-size free range, else carves from the tail of the
// best-fitting larger one, else grows the pool top. Free inserts into a
// begin-sorted free list and merges with adjacent neighbors.
// ----------------------------------------------------------------------------
// Sequence: allocate walks the list, one entry per cycle, to an exact fit or
//   its end, then drops that entry, carves the best range or grows the pool
//   top; free walks to the insert position and updates the list, with a drop
//   step to bridge two ranges; zero counts and frees past the pool top go
//   straight to response, which holds on output stalls; one request at a time.
// Reset: rst_n (synchronous) empties the free list and zeroes the pool top.
// ----------------------------------------------------------------------------
module best_fit_range_allocator #(
  parameter int POOL_SLOTS  = 4096,
  parameter int FREE_RANGES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [12:0] count, [24:13] start_req, [31:25] zero
  input  logic [0:0]  in_tuser,   // [0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [11:0] base, [15:12] zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  // Value width: slots 0..POOL_SLOTS
  localparam int VW = $clog2(POOL_SLOTS + 1);
  // Arithmetic width: room for start + count and a borrow bit
  localparam int AW = ((VW > bfra_pkg::COUNT_W) ? VW : bfra_pkg::COUNT_W) + 1;
  localparam int IW = (FREE_RANGES > 1) ? $clog2(FREE_RANGES) : 1;
  localparam int UW = $clog2(FREE_RANGES + 1);
  localparam int OUT_PAD = 16 - bfra_pkg::BASE_W;

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCANA = 3'd1;  // allocate: walk list for exact/best fit
  localparam logic [2:0] S_CARVE = 3'd2;  // shrink best range from its tail
  localparam logic [2:0] S_GROW  = 3'd3;  // extend the pool top
  localparam logic [2:0] S_DROP  = 3'd4;  // remove one list entry
  localparam logic [2:0] S_SCANF = 3'd5;  // free: find insert position, merge
  localparam logic [2:0] S_RESP  = 3'd6;  // hand result to the output register

  // Request fields
  logic                          in_kind;
  logic [bfra_pkg::COUNT_W-1:0]  in_count;
  logic [bfra_pkg::START_W-1:0]  in_start;
  logic                          in_fire;

  assign in_count = in_tdata[12:0];
  assign in_start = in_tdata[24:13];
  assign in_kind  = in_tuser[0];

  // Control registers
  logic [2:0]    state_r,    state_nxt;
  logic [UW-1:0] used_r,     used_nxt;
  logic [VW-1:0] pool_top_r, pool_top_nxt;
  logic          out_valid_r, out_valid_nxt;

  // Working registers
  logic [bfra_pkg::COUNT_W-1:0] cnt_r,   cnt_nxt;
  logic [bfra_pkg::START_W-1:0] start_r, start_nxt;
  logic [AW-1:0]                end_r,   end_nxt;
  logic [UW-1:0]                idx_r,   idx_nxt;
  logic [IW-1:0]                best_r,  best_nxt;
  logic [AW-1:0]                best_sz_r, best_sz_nxt;
  logic                         have_r,  have_nxt;
  logic [VW-1:0]                prev_end_r, prev_end_nxt;
  logic [IW-1:0]                drop_idx_r, drop_idx_nxt;
  logic [bfra_pkg::BASE_W-1:0]  res_base_r, res_base_nxt;
  bfra_pkg::status_t            res_status_r, res_status_nxt;
  logic [bfra_pkg::BASE_W-1:0]  out_base_r, out_base_nxt;
  bfra_pkg::status_t            out_status_r, out_status_nxt;

  // Free-list port
  logic [IW-1:0]      rd_idx;
  logic [VW-1:0]      rd_begin, rd_end;
  bfra_pkg::list_op_t op;
  logic [IW-1:0]      op_idx;
  logic [VW-1:0]      op_begin, op_end;

  // Shared adder/subtractor
  logic [AW-1:0] alu_a, alu_b, alu_y;
  logic          alu_sub;

  // Derived values
  logic [AW-1:0] rd_b_w, rd_e_w, sz_w, cnt_w, start_w, pool_top_w, pool_w;
  logic [UW-1:0] idx_dec;
  logic [IW-1:0] prev_idx;
  logic          in_range, list_full, mnext, mprev, out_free;

  bfra_list #(
    .DEPTH (FREE_RANGES),
    .VW    (VW)
  ) u_list (
    .clk      (clk),
    .rd_idx   (rd_idx),
    .rd_begin (rd_begin),
    .rd_end   (rd_end),
    .op       (op),
    .op_idx   (op_idx),
    .op_begin (op_begin),
    .op_end   (op_end)
  );

  // Carve reads the chosen best entry; every other state reads the walk index
  assign rd_idx = (state_r == S_CARVE) ? best_r : idx_r[IW-1:0];

  assign rd_b_w     = AW'(rd_begin);
  assign rd_e_w     = AW'(rd_end);
  assign cnt_w      = AW'(cnt_r);
  assign start_w    = AW'(start_r);
  assign pool_top_w = AW'(pool_top_r);
  assign pool_w     = AW'(POOL_SLOTS);

  // Route operands to the one adder by state
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        alu_a = AW'(in_start);
        alu_b = AW'(in_count);
      end
      S_SCANA: begin
        alu_a   = rd_e_w;
        alu_b   = rd_b_w;
        alu_sub = 1'b1;
      end
      S_CARVE: begin
        alu_a   = rd_e_w;
        alu_b   = cnt_w;
        alu_sub = 1'b1;
      end
      S_GROW: begin
        alu_a = pool_top_w;
        alu_b = cnt_w;
      end
      default: ;
    endcase
  end

  assign alu_y = alu_a + (alu_b ^ {AW{alu_sub}}) + AW'(alu_sub);

  // Range size, clamped to zero if end sits below begin
  assign sz_w      = alu_y[AW-1] ? '0 : alu_y;
  assign in_range  = (idx_r < used_r);
  assign list_full = (used_r == UW'(FREE_RANGES));
  assign idx_dec   = idx_r - UW'(1);
  assign prev_idx  = idx_dec[IW-1:0];
  // Merge tests at the insert position
  assign mnext     = in_range && (rd_b_w == end_r);
  assign mprev     = (idx_r != '0) && (AW'(prev_end_r) == start_w);
  assign out_free  = !out_valid_r || out_tready;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    state_nxt      = state_r;
    used_nxt       = used_r;
    pool_top_nxt   = pool_top_r;
    out_valid_nxt  = out_valid_r;
    cnt_nxt        = cnt_r;
    start_nxt      = start_r;
    end_nxt        = end_r;
    idx_nxt        = idx_r;
    best_nxt       = best_r;
    best_sz_nxt    = best_sz_r;
    have_nxt       = have_r;
    prev_end_nxt   = prev_end_r;
    drop_idx_nxt   = drop_idx_r;
    res_base_nxt   = res_base_r;
    res_status_nxt = res_status_r;
    out_base_nxt   = out_base_r;
    out_status_nxt = out_status_r;
    op             = bfra_pkg::OP_NONE;
    op_idx         = idx_r[IW-1:0];
    op_begin       = start_w[VW-1:0];
    op_end         = end_r[VW-1:0];

    // Drop the output beat once taken
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cnt_nxt        = in_count;
          start_nxt      = in_start;
          end_nxt        = alu_y;
          idx_nxt        = '0;
          have_nxt       = 1'b0;
          res_base_nxt   = '0;
          res_status_nxt = bfra_pkg::ST_OK;
          if (in_count == '0) begin
            state_nxt = S_RESP;
          end else if (in_kind == bfra_pkg::KIND_ALLOC) begin
            state_nxt = S_SCANA;
          end else if (alu_y > pool_top_w) begin
            // Free beyond the pool top: ignore
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_SCANF;
          end
        end
      end
      S_SCANA: begin
        if (!in_range) begin
          state_nxt = have_r ? S_CARVE : S_GROW;
        end else if (sz_w == cnt_w) begin
          // Exact fit: hand out the whole range and remove it
          res_base_nxt = rd_b_w[bfra_pkg::BASE_W-1:0];
          drop_idx_nxt = idx_r[IW-1:0];
          state_nxt    = S_DROP;
        end else begin
          // Keep the first range with the smallest size above count
          if (sz_w > cnt_w && (!have_r || sz_w < best_sz_r)) begin
            have_nxt    = 1'b1;
            best_nxt    = idx_r[IW-1:0];
            best_sz_nxt = sz_w;
          end
          idx_nxt = idx_r + UW'(1);
        end
      end
      S_CARVE: begin
        op           = bfra_pkg::OP_SET_END;
        op_idx       = best_r;
        op_end       = alu_y[VW-1:0];
        res_base_nxt = alu_y[bfra_pkg::BASE_W-1:0];
        state_nxt    = S_RESP;
      end
      S_GROW: begin
        if (alu_y > pool_w) begin
          res_status_nxt = bfra_pkg::ST_OOS;
        end else begin
          res_base_nxt = pool_top_w[bfra_pkg::BASE_W-1:0];
          pool_top_nxt = alu_y[VW-1:0];
        end
        state_nxt = S_RESP;
      end
      S_DROP: begin
        op        = bfra_pkg::OP_DROP;
        op_idx    = drop_idx_r;
        used_nxt  = used_r - UW'(1);
        state_nxt = S_RESP;
      end
      S_SCANF: begin
        if (in_range && rd_b_w < start_w) begin
          prev_end_nxt = rd_end;
          idx_nxt      = idx_r + UW'(1);
        end else begin
          priority if (mnext && mprev) begin
            // Bridge two neighbors: predecessor absorbs successor
            op           = bfra_pkg::OP_SET_END;
            op_idx       = prev_idx;
            op_end       = rd_end;
            drop_idx_nxt = idx_r[IW-1:0];
            state_nxt    = S_DROP;
          end else if (mnext) begin
            op        = bfra_pkg::OP_SET_BEGIN;
            op_begin  = start_w[VW-1:0];
            state_nxt = S_RESP;
          end else if (mprev) begin
            op        = bfra_pkg::OP_SET_END;
            op_idx    = prev_idx;
            op_end    = end_r[VW-1:0];
            state_nxt = S_RESP;
          end else if (list_full) begin
            res_status_nxt = bfra_pkg::ST_FULL;
            state_nxt      = S_RESP;
          end else begin
            op        = bfra_pkg::OP_INSERT;
            used_nxt  = used_r + UW'(1);
            state_nxt = S_RESP;
          end
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_base_nxt   = res_base_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      pool_top_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      pool_top_r  <= pool_top_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r        <= cnt_nxt;
    start_r      <= start_nxt;
    end_r        <= end_nxt;
    idx_r        <= idx_nxt;
    best_r       <= best_nxt;
    best_sz_r    <= best_sz_nxt;
    have_r       <= have_nxt;
    prev_end_r   <= prev_end_nxt;
    drop_idx_r   <= drop_idx_nxt;
    res_base_r   <= res_base_nxt;
    res_status_r <= res_status_nxt;
    out_base_r   <= out_base_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD{1'b0}}, out_base_r};
  assign out_tuser  = out_status_r;

  // Pool top stays inside the pool
  a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pool_top_w <= pool_w)
    else $error("pool top beyond pool size");

  // Pool top only grows, and only in the grow step
  a_pool_grow: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (pool_top_r != $past(pool_top_r)) |->
      ($past(state_r) == S_GROW) && (pool_top_r > $past(pool_top_r)))
    else $error("pool top changed outside grow");

  // List count moves only on drop or free insert
  a_used_move: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (used_r != $past(used_r)) |->
      ($past(state_r) == S_DROP) || ($past(state_r) == S_SCANF))
    else $error("free-list count changed unexpectedly");

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= UW'(FREE_RANGES))
    else $error("free-list count above depth");

  // A result beat appears only from the response step
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $rose(out_tvalid) |-> $past(state_r) == S_RESP)
    else $error("result raised outside response step");

endmodule
